// ===== hdl/ptd_pkg.sv =====
// Package for the phase-angle triac dimmer.
// Holds the shared constants, codes and structs; no dependencies.
package ptd_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int GATES_W      = 8;
    localparam int PHASE_W      = 16;
    localparam int LEVEL_W      = 8;
    localparam int CHAN_W       = 3;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [7:0]  VALUE_MAX_RST   = 8'd255;
    localparam logic [15:0] PHASE_MAX_RST   = 16'd255;
    localparam logic [15:0] PULSE_TICKS_RST = 16'd10;
    localparam logic [7:0]  DEBOUNCE_RST    = 8'd10;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_SET   = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_MAX   = 4'd0,
        CFG_PHASE_MAX   = 4'd1,
        CFG_PULSE_TICKS = 4'd2,
        CFG_DEBOUNCE    = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  value_max;
        logic [15:0] phase_max;
        logic [15:0] pulse_ticks;
        logic [7:0]  debounce_threshold;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic               zc_sample;
        logic [CHAN_W-1:0]  channel;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic               set_en;
        logic               tick_en;
        logic               clear;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
    } t_chan_ctrl;

endpackage

// ===== hdl/ptd_if.sv =====
// Handshake channel interfaces of the phase-angle triac dimmer.
// Depends on ptd_pkg for field widths.
interface ptd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic                        zc_sample;
    logic [ptd_pkg::CHAN_W-1:0]  channel;
    logic [ptd_pkg::LEVEL_W-1:0] level;

    modport source (output valid, opcode, zc_sample, channel, level, input ready);
    modport sink (input valid, opcode, zc_sample, channel, level, output ready);
endinterface

interface ptd_out_if;
    logic                        valid;
    logic                        ready;
    logic [ptd_pkg::GATES_W-1:0] gates;
    logic [ptd_pkg::PHASE_W-1:0] phase_count;

    modport source (output valid, gates, phase_count, input ready);
    modport sink (input valid, gates, phase_count, output ready);
endinterface

interface ptd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ptd_pkg::CFG_IDX_W-1:0]  index;
    logic [ptd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ptd_chan.sv =====
// One dimmer channel: stored level, pulse counter and gate decision.
// Depends on ptd_pkg.
module ptd_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptd_pkg::t_cfg       i_cfg,
    input  ptd_pkg::t_chan_ctrl i_ctrl,
    output logic                o_gate
);

    logic [ptd_pkg::LEVEL_W-1:0] r_level;
    logic [ptd_pkg::PHASE_W-1:0] r_pulse_count;
    logic [ptd_pkg::PHASE_W-1:0] n_pulse_count;
    logic [ptd_pkg::PHASE_W-1:0] w_base;
    logic [ptd_pkg::PHASE_W-1:0] w_lvl;
    logic                        w_fire;

    function automatic logic [ptd_pkg::PHASE_W-1:0] PHASE_W_EXT(
        input logic [ptd_pkg::LEVEL_W-1:0] v);
        PHASE_W_EXT = {{(ptd_pkg::PHASE_W - ptd_pkg::LEVEL_W){1'b0}}, v};
    endfunction

    always_comb begin
        w_base = i_ctrl.clear ? '0 : r_pulse_count;
        w_lvl  = (r_level < i_cfg.value_max) ? PHASE_W_EXT(r_level)
                                             : PHASE_W_EXT(i_cfg.value_max);
        w_fire = (w_lvl <= i_cfg.phase_max) && ((i_cfg.phase_max - w_lvl) < i_ctrl.phase);
        o_gate = w_fire && (w_base < i_cfg.pulse_ticks);
        n_pulse_count = o_gate ? w_base + 16'd1 : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= '0;
            r_pulse_count <= '0;
        end else begin
            if (i_ctrl.set_en) begin
                r_level <= i_ctrl.level;
            end
            if (i_ctrl.tick_en) begin
                r_pulse_count <= n_pulse_count;
            end
        end
    end

endmodule

// ===== hdl/phase_angle_triac_dimmer.sv =====
// Multi-channel phase-angle triac dimmer, top level.
// An input transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle; the input register moves whenever the result
// register is empty or being taken in the same cycle.
// Reset (synchronous, active low) clears levels, pulse counts, phase, detector and gates,
// and loads the register defaults. Depends on ptd_pkg, ptd_if and ptd_chan.
module phase_angle_triac_dimmer #(
    parameter int CHANNELS = ptd_pkg::CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptd_in_if.sink     i_in,
    ptd_cfg_if.sink    i_cfg,
    ptd_out_if.source  o_out
);

    ptd_pkg::t_cfg     r_cfg;
    ptd_pkg::t_in_item r_in;
    logic              r_in_valid;
    logic              r_out_valid;
    logic [ptd_pkg::GATES_W-1:0] r_out_gates;
    logic [ptd_pkg::PHASE_W-1:0] r_out_phase;

    logic [ptd_pkg::PHASE_W-1:0] r_phase;
    logic [7:0]                  r_debounce;
    logic                        r_disarmed;
    logic [ptd_pkg::GATES_W-1:0] r_gate_bits;

    logic [ptd_pkg::PHASE_W-1:0] n_phase;
    logic [7:0]                  n_debounce;
    logic                        n_disarmed;
    logic [ptd_pkg::GATES_W-1:0] n_gates;

    logic                        w_move;
    logic                        w_tick;
    logic                        w_clear;
    logic [ptd_pkg::PHASE_W-1:0] w_phase1;
    logic [ptd_pkg::PHASE_W-1:0] w_p;
    logic [CHANNELS-1:0]         w_gate;
    ptd_pkg::t_chan_ctrl         w_ctrl [CHANNELS];

    assign w_move      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_move;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.gates       = r_out_gates;
    assign o_out.phase_count = r_out_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_max          <= ptd_pkg::VALUE_MAX_RST;
            r_cfg.phase_max          <= ptd_pkg::PHASE_MAX_RST;
            r_cfg.pulse_ticks        <= ptd_pkg::PULSE_TICKS_RST;
            r_cfg.debounce_threshold <= ptd_pkg::DEBOUNCE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ptd_pkg::CFG_VALUE_MAX:   r_cfg.value_max          <= i_cfg.data[7:0];
                ptd_pkg::CFG_PHASE_MAX:   r_cfg.phase_max          <= i_cfg.data;
                ptd_pkg::CFG_PULSE_TICKS: r_cfg.pulse_ticks        <= i_cfg.data;
                ptd_pkg::CFG_DEBOUNCE:    r_cfg.debounce_threshold <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.opcode    <= i_in.opcode;
            r_in.zc_sample <= i_in.zc_sample;
            r_in.channel   <= i_in.channel;
            r_in.level     <= i_in.level;
        end
    end

    always_comb begin
        w_tick   = w_move && (r_in.opcode == ptd_pkg::OP_TICK);
        w_clear  = w_tick && r_in.zc_sample && !r_disarmed;
        w_phase1 = w_clear ? '0 : r_phase;
        w_p      = (w_phase1 < r_cfg.phase_max) ? w_phase1 : r_cfg.phase_max;
        n_phase  = (w_phase1 < r_cfg.phase_max) ? w_phase1 + 16'd1 : w_phase1;

        n_debounce = r_debounce;
        n_disarmed = r_disarmed;
        if (r_in.zc_sample) begin
            if (!r_disarmed) begin
                n_disarmed = 1'b1;
                n_debounce = '0;
            end
        end else if (r_debounce < r_cfg.debounce_threshold) begin
            n_debounce = r_debounce + 8'd1;
        end else begin
            n_disarmed = 1'b0;
        end
    end

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_chan
            always_comb begin
                w_ctrl[c].set_en  = w_move && (r_in.opcode == ptd_pkg::OP_SET)
                                    && (32'(r_in.channel) == c);
                w_ctrl[c].tick_en = w_tick;
                w_ctrl[c].clear   = w_clear;
                w_ctrl[c].level   = r_in.level;
                w_ctrl[c].phase   = w_p;
            end

            ptd_chan u_chan (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (r_cfg),
                .i_ctrl  (w_ctrl[c]),
                .o_gate  (w_gate[c])
            );
        end

        for (c = 0; c < ptd_pkg::GATES_W; c++) begin : g_gate
            if (c < CHANNELS) begin : g_used
                assign n_gates[c] = w_gate[c];
            end else begin : g_unused
                assign n_gates[c] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_debounce  <= '0;
            r_disarmed  <= 1'b0;
            r_gate_bits <= '0;
        end else if (w_tick) begin
            r_phase     <= n_phase;
            r_debounce  <= n_debounce;
            r_disarmed  <= n_disarmed;
            r_gate_bits <= n_gates;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_gates <= w_tick ? n_gates : r_gate_bits;
            r_out_phase <= w_p;
        end
    end

endmodule

// ===== hdl/ptd_checker.sv =====
// Port-level checker for the phase-angle triac dimmer, bound to the top level.
// Depends on ptd_pkg for field widths.
module ptd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ptd_pkg::GATES_W-1:0] i_out_gates,
    input logic [ptd_pkg::PHASE_W-1:0] i_out_phase
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_gates) && $stable(i_out_phase))
        else $error("Result payload changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while the result stage is empty.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid ##1 !i_out_valid |=> i_out_valid)
        else $error("Accepted transaction produced no result.");

endmodule

bind phase_angle_triac_dimmer ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_gates (o_out.gates),
    .i_out_phase (o_out.phase_count)
);

// ===== test/tb_phase_angle_triac_dimmer.sv =====
// Self-checking testbench for the phase-angle triac dimmer (phase_angle_triac_dimmer).
// Uses ptd_pkg and the ptd_if interfaces; a directed table is followed by random half-cycle
// traffic; each result is compared with an in-bench dimmer model or a preset in the table.
`timescale 1ns / 100ps

module tb_phase_angle_triac_dimmer;

    localparam int CH          = ptd_pkg::CHANNELS_DEF;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 500000;
    localparam int DIR_ROWS    = 36;

    localparam logic [ptd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

    typedef enum bit {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    typedef struct packed {
        logic [ptd_pkg::GATES_W-1:0] gates;
        logic [ptd_pkg::PHASE_W-1:0] phase_count;
    } t_dim_result;

    typedef struct packed {
        bit          preset;
        t_dim_result res;
    } t_preset;

    typedef struct {
        t_row_kind                      kind;
        logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data;
        ptd_pkg::t_in_item              item;
        bit                             preset;
        t_dim_result                    res;
    } t_dir_row;

    localparam ptd_pkg::t_in_item NO_ITEM = '0;
    localparam t_dim_result       NO_RES  = '0;

    logic i_clk;
    logic i_rst_n;

    ptd_in_if  in_if ();
    ptd_cfg_if cfg_if ();
    ptd_out_if out_if ();

    phase_angle_triac_dimmer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    ptd_pkg::t_cfg    cfg_model = '{ptd_pkg::VALUE_MAX_RST, ptd_pkg::PHASE_MAX_RST,
                                    ptd_pkg::PULSE_TICKS_RST, ptd_pkg::DEBOUNCE_RST};
    logic [7:0]       lvl_store [CH] = '{default: '0};
    logic [15:0]      pulse_cnt [CH] = '{default: '0};
    logic [15:0]      phase     = '0;
    logic [7:0]       deb_cnt   = '0;
    bit               disarmed  = 1'b0;
    logic [7:0]       gate_bits = '0;

    t_dim_result      pending_results [$];
    t_preset          preset_q [$];

    int  err_count   = 0;
    int  n_items     = 0;
    int  n_results   = 0;
    int  n_lit       = 0;
    int  n_cfg       = 0;
    int  n_holds     = 0;
    int  cycle_cnt   = 0;
    bit  hold_req    = 1'b0;
    bit  rx_steady   = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b0, 3'd0, 8'd255}, 1'b1, '{8'h00, 16'd0}},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b1, '{8'h00, 16'd0}},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b1, 3'd0, 8'd0},   1'b1, '{8'h00, 16'd0}},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b1, 3'd7, 8'd255}, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b1, 3'd7, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_CFG, CFG_UNUSED_IDX,           16'hFFFF, NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PHASE_MAX,   16'd2,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PULSE_TICKS, 16'd2,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_DEBOUNCE,    16'd0,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_VALUE_MAX,   16'd3,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b0, 3'd3, 8'd200}, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b0, 3'd5, 8'd2},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b1, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_VALUE_MAX,   16'd255,  NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PHASE_MAX,   16'd0,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b1, '{8'h00, 16'd0}},
        '{ROW_CFG, ptd_pkg::CFG_PHASE_MAX,   16'hFFFF, NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PULSE_TICKS, 16'hFFFF, NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_DEBOUNCE,    16'd255,  NO_ITEM, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b1, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b0, 3'd6, 8'd255}, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PULSE_TICKS, 16'd0,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_VALUE_MAX,   16'd0,    NO_ITEM, 1'b0, NO_RES},
        '{ROW_CFG, ptd_pkg::CFG_PHASE_MAX,   16'd255,  NO_ITEM, 1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b1, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_TICK, 1'b0, 3'd0, 8'd0},   1'b0, NO_RES},
        '{ROW_ITEM, '0, '0, '{ptd_pkg::OP_SET,  1'b0, 3'd2, 8'h55},  1'b0, NO_RES}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("tb_phase_angle_triac_dimmer failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_cfg(input logic [15:0] top, input int typical);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return top;
        end
        return 16'($urandom_range(1, typical));
    endfunction

    function automatic logic [15:0] held_phase();
        return (phase < cfg_model.phase_max) ? phase : cfg_model.phase_max;
    endfunction

    task automatic dimmer_step(input ptd_pkg::t_in_item it, output t_dim_result res);
        logic [ptd_pkg::PHASE_W-1:0] p;
        logic [ptd_pkg::PHASE_W-1:0] lvl;
        int c;
        if (it.opcode == ptd_pkg::OP_SET) begin
            lvl_store[it.channel] = it.level;
            res.gates = gate_bits;
            res.phase_count = held_phase();
        end else begin
            if (it.zc_sample) begin
                if (!disarmed) begin
                    disarmed = 1'b1;
                    phase = '0;
                    deb_cnt = '0;
                    for (c = 0; c < CH; c++) pulse_cnt[c] = '0;
                end
            end else if (deb_cnt < cfg_model.debounce_threshold) begin
                deb_cnt++;
            end else begin
                disarmed = 1'b0;
            end
            p = held_phase();
            gate_bits = '0;
            for (c = 0; c < CH; c++) begin
                lvl = 16'((lvl_store[c] < cfg_model.value_max) ? lvl_store[c]
                                                               : cfg_model.value_max);
                if (lvl <= cfg_model.phase_max && (cfg_model.phase_max - lvl) < p
                        && pulse_cnt[c] < cfg_model.pulse_ticks) begin
                    pulse_cnt[c]++;
                    if (c < ptd_pkg::GATES_W) gate_bits[c] = 1'b1;
                end
            end
            if (phase < cfg_model.phase_max) phase++;
            res.gates = gate_bits;
            res.phase_count = p;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, n_results, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        ptd_pkg::t_in_item it;
        t_dim_result       pred;
        t_dim_result       want;
        t_preset           tag;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(out_if.gates), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_if.gates !== want.gates)
                        report_mismatch("gates", int'(out_if.gates), int'(want.gates));
                    if (out_if.phase_count !== want.phase_count)
                        report_mismatch("phase_count", int'(out_if.phase_count),
                                        int'(want.phase_count));
                    if (out_if.gates != '0) n_lit++;
                end
                n_results++;
            end
            if (in_if.valid && in_if.ready) begin
                it.opcode = in_if.opcode;
                it.zc_sample = in_if.zc_sample;
                it.channel = in_if.channel;
                it.level = in_if.level;
                dimmer_step(it, pred);
                tag = preset_q.pop_front();
                pending_results.push_back(tag.preset ? tag.res : pred);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    ptd_pkg::CFG_VALUE_MAX:   cfg_model.value_max = cfg_if.data[7:0];
                    ptd_pkg::CFG_PHASE_MAX:   cfg_model.phase_max = cfg_if.data;
                    ptd_pkg::CFG_PULSE_TICKS: cfg_model.pulse_ticks = cfg_if.data;
                    ptd_pkg::CFG_DEBOUNCE:    cfg_model.debounce_threshold = cfg_if.data[7:0];
                    default: ;
                endcase
                n_cfg++;
            end
        end
    end

    initial begin : receiver
        int run;
        int g;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                out_if.ready <= 1'b1;
                run = $urandom_range(1, 8);
                repeat (run) @(posedge i_clk);
                g = rx_steady ? 0 : pick_gap();
                if (g > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    task automatic drive_item(input ptd_pkg::t_in_item it, input bit preset,
                              input t_dim_result res, input int gap);
        t_preset tag;
        tag.preset = preset;
        tag.res = res;
        preset_q.push_back(tag);
        in_if.valid <= 1'b1;
        in_if.opcode <= it.opcode;
        in_if.zc_sample <= it.zc_sample;
        in_if.channel <= it.channel;
        in_if.level <= it.level;
        do @(posedge i_clk); while (!in_if.ready);
        n_items++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic [ptd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptd_pkg::CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin : stimulus
        ptd_pkg::t_in_item it;
        logic [15:0]       cur_pm;
        int                hi_left;
        int                lo_left;
        int                gap;
        bit                tx_steady;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.opcode <= ptd_pkg::OP_TICK;
        in_if.zc_sample <= 1'b0;
        in_if.channel <= '0;
        in_if.level <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle();
                write_cfg(dir_rows[r].cfg_idx, dir_rows[r].cfg_data);
            end else begin
                drive_item(dir_rows[r].item, dir_rows[r].preset, dir_rows[r].res, pick_gap());
            end
        end

        hi_left = 0;
        lo_left = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            cur_pm = pick_cfg(16'hFFFF, 60);
            write_cfg(ptd_pkg::CFG_VALUE_MAX, pick_cfg(16'd255, 255));
            write_cfg(ptd_pkg::CFG_PHASE_MAX, cur_pm);
            write_cfg(ptd_pkg::CFG_PULSE_TICKS, pick_cfg(16'hFFFF, 20));
            write_cfg(ptd_pkg::CFG_DEBOUNCE, pick_cfg(16'd255, 6));
            if (ph % 3 == 2)
                write_cfg(CFG_UNUSED_IDX + 4'(-$urandom_range(0, 11)), 16'($urandom));
            tx_steady = (ph % 4 == 1);
            rx_steady = (ph % 4 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 3 && k == 50) hold_req = 1'b1;
                if (ph == 6 && k == 80) settle();
                it.channel = 3'($urandom_range(0, 7));
                it.level = 8'($urandom_range(0, 255));
                it.zc_sample = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) begin
                    it.opcode = ptd_pkg::OP_SET;
                    if ($urandom_range(0, 1) == 1)
                        it.level = 8'($urandom_range(0, (cur_pm > 255) ? 255 : cur_pm));
                end else begin
                    it.opcode = ptd_pkg::OP_TICK;
                    if ($urandom_range(0, 11) != 0) begin
                        if (hi_left > 0) begin
                            it.zc_sample = 1'b1;
                            hi_left--;
                        end else if (lo_left > 0) begin
                            it.zc_sample = 1'b0;
                            lo_left--;
                        end else begin
                            it.zc_sample = 1'b1;
                            hi_left = $urandom_range(0, 2);
                            lo_left = (cur_pm > 80) ? $urandom_range(20, 80)
                                                    : cur_pm + $urandom_range(0, 4);
                        end
                    end
                end
                gap = (tx_steady || (ph == 3 && k >= 50 && k < 110)) ? 0 : pick_gap();
                drive_item(it, 1'b0, NO_RES, gap);
            end
        end

        settle();
        if (pending_results.size() != 0)
            report_mismatch("results left pending", pending_results.size(), 0);
        $display("Summary: %0d items in, %0d results checked, %0d with a gate on.",
                 n_items, n_results, n_lit);
        $display("Summary: %0d register writes, %0d long output hold-offs, %0d errors.",
                 n_cfg, n_holds, err_count);
        if (err_count == 0) begin
            $display("tb_phase_angle_triac_dimmer passed");
        end else begin
            $display("tb_phase_angle_triac_dimmer failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ptd_pkg.sv
hdl/ptd_if.sv
hdl/ptd_chan.sv
hdl/phase_angle_triac_dimmer.sv
hdl/ptd_checker.sv
test/tb_phase_angle_triac_dimmer.sv
